// File: sv/dcdq_pkg.sv
// Shared types and codes of the draw command dispatch queue.
package dcdq_pkg;

	localparam logic [1:0] MODE_ENQ = 2'd0;
	localparam logic [1:0] MODE_GPU = 2'd1;
	localparam logic [1:0] MODE_DMA = 2'd2;

	localparam logic SRC_DMA = 1'b0;
	localparam logic SRC_GPU = 1'b1;

	typedef enum logic [1:0] {
		OP_ENQ    = 2'd0,
		OP_RETIRE = 2'd1,
		OP_IGNORE = 2'd2
	} op_t;

	typedef struct packed {
		logic [31:0] command;
		logic [31:0] arg_one;
		logic [31:0] arg_two;
		logic [31:0] arg_three;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		cmd_t cmd;
	} item_t;

	typedef struct packed {
		logic       overflow;
		logic [4:0] position;
		logic       issue_valid;
		cmd_t       issue;
		logic       drained;
		logic [4:0] occupancy;
	} res_t;

endpackage

// File: sv/draw_command_dispatch_queue.sv
// Top level of the draw command dispatch queue.
// Every input item gives one result. The front end classifies an item in the cycle it is
// taken and parks it in a two-entry queue; the back end then finishes an enqueue, an
// ignored event, a drain or an event on an empty queue from the queue head, and a
// completion that issues a stored command by way of the registered read of the pending
// ring. The user must write the completion source register only while the block is idle;
// the block itself does not enforce this. The pending ring holds QUEUE_DEPTH entries; no
// clearing pass is needed after reset.
module draw_command_dispatch_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] command,
	input  logic [31:0] arg_one,
	input  logic [31:0] arg_two,
	input  logic [31:0] arg_three,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        overflow,
	output logic [4:0]  position,
	output logic        issue_valid,
	output logic [31:0] issue_command,
	output logic [31:0] issue_arg_one,
	output logic [31:0] issue_arg_two,
	output logic [31:0] issue_arg_three,
	output logic        drained,
	output logic [4:0]  occupancy
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic            push, fifo_full, pop, fifo_valid, rd_busy;
	dcdq_pkg::item_t push_item, fifo_item;
	dcdq_pkg::res_t  res;
	logic [CW-1:0]   count;

	dcdq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.command     (command),
		.arg_one     (arg_one),
		.arg_two     (arg_two),
		.arg_three   (arg_three),
		.fifo_full   (fifo_full),
		.push        (push),
		.push_item   (push_item)
	);

	dcdq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (fifo_full),
		.pop       (pop),
		.valid     (fifo_valid),
		.head      (fifo_item)
	);

	dcdq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_valid (fifo_valid),
		.fifo_item  (fifo_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res        (res),
		.count      (count),
		.rd_busy    (rd_busy)
	);

	assign overflow        = res.overflow;
	assign position        = res.position;
	assign issue_valid     = res.issue_valid;
	assign issue_command   = res.issue.command;
	assign issue_arg_one   = res.issue.arg_one;
	assign issue_arg_two   = res.issue.arg_two;
	assign issue_arg_three = res.issue.arg_three;
	assign drained         = res.drained;
	assign occupancy       = res.occupancy;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(QUEUE_DEPTH))
		else $error("occupancy count above queue depth");

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_busy |-> !out_valid)
		else $error("ring read pending while output register holds an item");

	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		rd_busy |=> !rd_busy)
		else $error("ring read lasted more than one cycle");

	a_drain_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && drained) |-> (!issue_valid && !overflow && occupancy == 5'd0))
		else $error("drain reported together with issue or overflow");

endmodule

// File: sv/dcdq_front.sv
// Front end: completion source register and item classification.
module dcdq_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [31:0]          command,
	input  logic [31:0]          arg_one,
	input  logic [31:0]          arg_two,
	input  logic [31:0]          arg_three,
	input  logic                 fifo_full,
	output logic                 push,
	output dcdq_pkg::item_t      push_item
);

	logic src_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= dcdq_pkg::SRC_DMA;
		end else if (cfg_wr_en) begin
			src_q <= cfg_wr_data;
		end
	end

	always_comb begin
		push_item.cmd.command   = command;
		push_item.cmd.arg_one   = arg_one;
		push_item.cmd.arg_two   = arg_two;
		push_item.cmd.arg_three = arg_three;
		case (mode)
			dcdq_pkg::MODE_ENQ: push_item.op = dcdq_pkg::OP_ENQ;
			dcdq_pkg::MODE_GPU: push_item.op = (src_q == dcdq_pkg::SRC_GPU) ?
				dcdq_pkg::OP_RETIRE : dcdq_pkg::OP_IGNORE;
			dcdq_pkg::MODE_DMA: push_item.op = (src_q == dcdq_pkg::SRC_DMA) ?
				dcdq_pkg::OP_RETIRE : dcdq_pkg::OP_IGNORE;
			default: push_item.op = dcdq_pkg::OP_IGNORE;
		endcase
	end

	assign in_stall = fifo_full;
	assign push     = in_valid && !fifo_full;

endmodule

// File: sv/dcdq_fifo.sv
// Two-entry queue of classified items between front and back end.
module dcdq_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dcdq_pkg::item_t      push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 valid,
	output dcdq_pkg::item_t      head
);

	dcdq_pkg::item_t ent_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign full  = cnt_q[1];
	assign valid = (cnt_q != 2'd0);
	assign head  = ent_q[rd_q];

endmodule

// File: sv/dcdq_back.sv
// Back end: pending ring, counters and the registered result.
module dcdq_back #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fifo_valid,
	input  dcdq_pkg::item_t            fifo_item,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output dcdq_pkg::res_t             res,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
	output logic                       rd_busy
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_RUN  = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t          state_q, state_d;
	logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
	logic [CW-1:0]   count_q, count_d;
	logic            out_valid_q;
	dcdq_pkg::res_t  res_q, res_d;
	dcdq_pkg::cmd_t  mem_q [QUEUE_DEPTH];
	dcdq_pkg::cmd_t  rdata_q;
	logic            mem_we, mem_re, load, out_free;
	logic [31:0]     cnt_w;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign out_free = !out_valid_q || !out_stall;
	assign cnt_w    = 32'(count_q);
	assign pop      = (state_q == ST_RUN) && fifo_valid && out_free;

	always_comb begin
		logic [31:0] nxt_w;
		res_d   = '0;
		load    = 1'b0;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		count_d = count_q;
		wp_d    = wp_q;
		rp_d    = rp_q;
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (fifo_valid && out_free) begin
					case (fifo_item.op)
						dcdq_pkg::OP_ENQ: begin
							load           = 1'b1;
							res_d.position = cnt_w[4:0];
							if (count_q == '0) begin
								count_d           = CW'(1);
								res_d.issue_valid = 1'b1;
								res_d.issue       = fifo_item.cmd;
							end else if (count_q >= CW'(QUEUE_DEPTH)) begin
								res_d.overflow = 1'b1;
							end else begin
								mem_we  = 1'b1;
								wp_d    = ptr_inc(wp_q);
								count_d = count_q + CW'(1);
							end
						end
						dcdq_pkg::OP_RETIRE: begin
							if (count_q == '0) begin
								load = 1'b1;
							end else if (count_q == CW'(1)) begin
								load          = 1'b1;
								count_d       = '0;
								res_d.drained = 1'b1;
							end else begin
								mem_re  = 1'b1;
								rp_d    = ptr_inc(rp_q);
								count_d = count_q - CW'(1);
								state_d = ST_READ;
							end
						end
						default: load = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				load              = 1'b1;
				res_d.issue_valid = 1'b1;
				res_d.issue       = rdata_q;
				state_d           = ST_RUN;
			end
			default: state_d = ST_RUN;
		endcase
		nxt_w           = 32'(count_d);
		res_d.occupancy = nxt_w[4:0];
	end

	// pending ring, registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wp_q] <= fifo_item.cmd;
		end
		if (mem_re) begin
			rdata_q <= mem_q[rp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			wp_q        <= '0;
			rp_q        <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			count_q <= count_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign count     = count_q;
	assign rd_busy   = (state_q == ST_READ);

endmodule

// File: sim/draw_command_dispatch_queue_tb.sv
`timescale 1ns / 100ps
// Testbench of draw_command_dispatch_queue: directed and random items against a queue model.
module draw_command_dispatch_queue_tb;

	localparam int DEPTH = 16;
	localparam logic [1:0] MODE_RSVD = 2'd3;
	localparam int HOLD_CYCLES = 100;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int REPORT_MAX = 10;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_style_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [31:0] command;
	logic [31:0] arg_one;
	logic [31:0] arg_two;
	logic [31:0] arg_three;
	logic        out_valid;
	logic        out_stall;
	logic        overflow;
	logic [4:0]  position;
	logic        issue_valid;
	logic [31:0] issue_command;
	logic [31:0] issue_arg_one;
	logic [31:0] issue_arg_two;
	logic [31:0] issue_arg_three;
	logic        drained;
	logic [4:0]  occupancy;

	// model of the queue
	dcdq_pkg::cmd_t ring [DEPTH];
	logic [3:0]     ring_rd = '0;
	logic [3:0]     ring_wr = '0;
	logic [4:0]     queued = '0;
	logic           src_sel = dcdq_pkg::SRC_DMA;
	dcdq_pkg::res_t expected_results [$];

	int           mismatches = 0;
	int           idle_cycles = 0;
	stall_style_t stall_style = STALL_NONE;
	bit           gaps_on = 1'b0;
	int           burst_left = 0;
	int           hold_reqs = 0;
	logic         active_src = dcdq_pkg::SRC_DMA;

	draw_command_dispatch_queue #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.command        (command),
		.arg_one        (arg_one),
		.arg_two        (arg_two),
		.arg_three      (arg_three),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.overflow       (overflow),
		.position       (position),
		.issue_valid    (issue_valid),
		.issue_command  (issue_command),
		.issue_arg_one  (issue_arg_one),
		.issue_arg_two  (issue_arg_two),
		.issue_arg_three(issue_arg_three),
		.drained        (drained),
		.occupancy      (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic dcdq_pkg::res_t dispatch_predict(logic [1:0] m, dcdq_pkg::cmd_t c);
		dcdq_pkg::res_t r;
		r = '0;
		if (m == dcdq_pkg::MODE_ENQ) begin
			r.position = queued;
			if (queued == 0) begin
				queued = 5'd1;
				r.issue_valid = 1'b1;
				r.issue = c;
			end else if (queued >= DEPTH) begin
				r.overflow = 1'b1;
			end else begin
				ring[ring_wr] = c;
				ring_wr = ring_wr + 4'd1;
				queued = queued + 5'd1;
			end
		end else if (((m == dcdq_pkg::MODE_GPU && src_sel == dcdq_pkg::SRC_GPU) ||
				(m == dcdq_pkg::MODE_DMA && src_sel == dcdq_pkg::SRC_DMA)) &&
				queued != 0) begin
			queued = queued - 5'd1;
			if (queued != 0) begin
				r.issue_valid = 1'b1;
				r.issue = ring[ring_rd];
				ring_rd = ring_rd + 4'd1;
			end else begin
				r.drained = 1'b1;
			end
		end
		r.occupancy = queued;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		dcdq_pkg::res_t got;
		dcdq_pkg::res_t want;
		if (!arst_n) begin
			ring_rd = '0;
			ring_wr = '0;
			queued = '0;
			src_sel = dcdq_pkg::SRC_DMA;
		end else begin
			if (out_valid && !out_stall) begin
				got = {overflow, position, issue_valid, issue_command, issue_arg_one,
					issue_arg_two, issue_arg_three, drained, occupancy};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: result with nothing expected, occupancy %0d",
							$time, occupancy);
				end else begin
					want = expected_results.pop_front();
					if (got.overflow !== want.overflow || got.position !== want.position ||
							got.issue_valid !== want.issue_valid ||
							got.issue.command !== want.issue.command ||
							got.issue.arg_one !== want.issue.arg_one ||
							got.issue.arg_two !== want.issue.arg_two ||
							got.issue.arg_three !== want.issue.arg_three ||
							got.drained !== want.drained || got.occupancy !== want.occupancy) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("%0t: result mismatch", $time);
							$display("  expected ovf %b pos %0d iss %b %h %h %h %h drn %b occ %0d",
								want.overflow, want.position, want.issue_valid,
								want.issue.command, want.issue.arg_one, want.issue.arg_two,
								want.issue.arg_three, want.drained, want.occupancy);
							$display("  actual   ovf %b pos %0d iss %b %h %h %h %h drn %b occ %0d",
								got.overflow, got.position, got.issue_valid,
								got.issue.command, got.issue.arg_one, got.issue.arg_two,
								got.issue.arg_three, got.drained, got.occupancy);
						end
					end
				end
			end
			if (cfg_wr_en)
				src_sel = cfg_wr_data;
			if (in_valid && !in_stall)
				expected_results.push_back(dispatch_predict(mode,
					{command, arg_one, arg_two, arg_three}));
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("draw_command_dispatch_queue_tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side backpressure; a hold request stalls for a long stretch
	initial begin : receiver
		int hold_left;
		int beat;
		int seen;
		hold_left = 0;
		beat = 0;
		seen = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			beat++;
			if (hold_reqs != seen) begin
				seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_style)
					STALL_NONE:   out_stall <= 1'b0;
					STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
					default:      out_stall <= ((beat % 7) >= 4);
				endcase
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic dcdq_pkg::cmd_t rand_cmd();
		dcdq_pkg::cmd_t c;
		c.command = rand_word();
		c.arg_one = rand_word();
		c.arg_two = rand_word();
		c.arg_three = rand_word();
		return c;
	endfunction

	task automatic send_item(logic [1:0] m, dcdq_pkg::cmd_t c);
		int gap;
		@(negedge clk);
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		mode <= m;
		{command, arg_one, arg_two, arg_three} <= c;
		do @(posedge clk); while (in_stall);
	endtask

	// register write only with the block drained
	task automatic set_source(logic s);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= s;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		active_src = s;
	endtask

	task automatic test_empty_and_foreign_events();
		dcdq_pkg::cmd_t zeros;
		dcdq_pkg::cmd_t ones;
		zeros = '0;
		ones = '1;
		set_source(dcdq_pkg::SRC_DMA);
		gaps_on = 1'b0;
		stall_style = STALL_NONE;
		send_item(dcdq_pkg::MODE_DMA, rand_cmd());
		send_item(dcdq_pkg::MODE_GPU, rand_cmd());
		send_item(MODE_RSVD, ones);
		send_item(dcdq_pkg::MODE_ENQ, zeros);
		send_item(dcdq_pkg::MODE_ENQ, ones);
		send_item(dcdq_pkg::MODE_ENQ, rand_cmd());
		send_item(dcdq_pkg::MODE_GPU, ones);
		send_item(MODE_RSVD, zeros);
		send_item(dcdq_pkg::MODE_DMA, zeros);
		send_item(dcdq_pkg::MODE_DMA, zeros);
		send_item(dcdq_pkg::MODE_DMA, zeros);
		send_item(dcdq_pkg::MODE_DMA, ones);
	endtask

	task automatic test_gpu_source();
		set_source(dcdq_pkg::SRC_GPU);
		gaps_on = 1'b1;
		stall_style = STALL_RANDOM;
		repeat (3) send_item(dcdq_pkg::MODE_ENQ, rand_cmd());
		send_item(dcdq_pkg::MODE_DMA, rand_cmd());
		repeat (3) send_item(dcdq_pkg::MODE_GPU, rand_cmd());
		send_item(dcdq_pkg::MODE_GPU, rand_cmd());
		send_item(MODE_RSVD, rand_cmd());
	endtask

	// receiver held off while enqueues keep coming: fills the ring past full
	task automatic test_fill_and_overflow();
		set_source(dcdq_pkg::SRC_DMA);
		gaps_on = 1'b0;
		stall_style = STALL_PERIODIC;
		hold_reqs++;
		repeat (DEPTH + 3) send_item(dcdq_pkg::MODE_ENQ, rand_cmd());
		repeat (DEPTH + 1) send_item(dcdq_pkg::MODE_DMA, rand_cmd());
	endtask

	task automatic test_random_traffic();
		int enq_pct;
		int pick;
		logic [1:0] m;
		for (int ph = 0; ph < 8; ph++) begin
			set_source((ph % 2 == 1) ? dcdq_pkg::SRC_GPU : dcdq_pkg::SRC_DMA);
			stall_style = stall_style_t'(ph % 3);
			gaps_on = (ph % 4 != 3);
			enq_pct = 30 + 20 * (ph % 4);
			for (int n = 0; n < 43; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < enq_pct) begin
					m = dcdq_pkg::MODE_ENQ;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 85)
						m = (active_src == dcdq_pkg::SRC_GPU) ?
							dcdq_pkg::MODE_GPU : dcdq_pkg::MODE_DMA;
					else if (pick < 95)
						m = (active_src == dcdq_pkg::SRC_GPU) ?
							dcdq_pkg::MODE_DMA : dcdq_pkg::MODE_GPU;
					else
						m = MODE_RSVD;
				end
				send_item(m, rand_cmd());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid = 1'b0;
		mode = dcdq_pkg::MODE_ENQ;
		command = '0;
		arg_one = '0;
		arg_two = '0;
		arg_three = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_and_foreign_events();
		test_gpu_source();
		test_fill_and_overflow();
		test_random_traffic();

		@(negedge clk);
		in_valid <= 1'b0;
		stall_style = STALL_NONE;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("draw_command_dispatch_queue_tb passed");
		else
			$display("draw_command_dispatch_queue_tb failed");
		$finish;
	end

endmodule

// File: draw_command_dispatch_queue.f
sv/dcdq_pkg.sv
sv/dcdq_front.sv
sv/dcdq_fifo.sv
sv/dcdq_back.sv
sv/draw_command_dispatch_queue.sv
sim/draw_command_dispatch_queue_tb.sv
